[rtl/stick_radial_deadzone_hysteresis_defines.svh]
`ifndef STICK_RADIAL_DEADZONE_HYSTERESIS_DEFINES_SVH
`define STICK_RADIAL_DEADZONE_HYSTERESIS_DEFINES_SVH

// Assertion helpers for the stick conditioning block.
// The consequent must hold in the same cycle as the antecedent.
`define SRDH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srdh check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srdh check failed");

`endif

[rtl/srdh_pkg.sv]
`timescale 1ns / 1ps

package srdh_pkg;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE  = 2'd2;

   localparam int unsigned DEADZONE_RESET = 4915;
   localparam int unsigned PRESS_RESET    = 16384;
   localparam int unsigned RELEASE_RESET  = 14745;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_DIFF,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_D,
      ST_SCALE,
      ST_BIAS,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } srdh_state_type;

endpackage

[rtl/stick_radial_deadzone_hysteresis.sv]
`timescale 1ns / 1ps
// A new sample is taken only in the idle state, once the previous result has gone into the
// output register; a magnitude at or inside the deadzone skips the multiplies and the divider.
// The work on each sample is done by the bit-serial square root (two bits of the sum per
// cycle) and the restoring divider (one bit per cycle).
// Reset is synchronous, active high: it clears the direction latches and the output
// valid, and loads the level registers with 4915, 16384 and 14745.
module stick_radial_deadzone_hysteresis #(
   parameter int SAMPLE_BITS = 16,
   localparam int REQ_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * SAMPLE_BITS + 12 + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // raw_x, raw_y
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cond_x, cond_y, held_mask, pressed_mask, released_mask
   output logic [RSP_W-1:0]                  rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [srdh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [SAMPLE_BITS-2:0]            csr_wdata
);

   import srdh_pkg::*;

   localparam int N  = SAMPLE_BITS;
   localparam int LW = SAMPLE_BITS - 1;
   localparam int CW = $clog2(SAMPLE_BITS + 1);
   localparam logic [LW-1:0] FS_LV = '1;

   srdh_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [3:0]     latch_ff, latch_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]  dz_ff, dz_in;
   logic [LW-1:0]  press_ff, press_in;
   logic [LW-1:0]  rel_ff, rel_in;

   logic [LW-1:0]    mag_ff [2];
   logic [LW-1:0]    mag_in [2];
   logic             neg_ff [2];
   logic             neg_in [2];
   logic [2*N-1:0]   s_ff, s_in;
   logic [N:0]       root_rem_ff, root_rem_in;
   logic [N-1:0]     root_ff, root_in;
   logic [N-1:0]     diff_ff, diff_in;
   logic [2*N-1:0]   den_ff, den_in;
   logic [3*N-1:0]   num_ff [2];
   logic [3*N-1:0]   num_in [2];
   logic [2*N-1:0]   rem_ff [2];
   logic [2*N-1:0]   rem_in [2];
   logic [LW-1:0]    q_ff [2];
   logic [LW-1:0]    q_in [2];
   logic             sat_ff [2];
   logic             sat_in [2];
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [N-1:0]   raw_w [2];
   logic [N-1:0]   abs_w [2];
   logic [LW-1:0]  mag_w [2];
   logic [LW-1:0]  dz_eff;
   logic [N-1:0]   mul_a, mul_b;
   logic [2*N-1:0] prod;
   logic [2*N:0]   dd;
   logic [LW-1:0]  qf_w [2];
   logic [N-1:0]   cond_w [2];
   logic [N:0]     defl_w [4];
   logic [3:0]     latch_next, pressed_w, released_w;

   // A deadzone at full scale behaves as one step below it, so the divisor stays nonzero.
   assign dz_eff = (dz_ff == FS_LV) ? (FS_LV - LW'(1)) : dz_ff;
   assign prod   = mul_a * mul_b;
   assign dd     = {den_ff, 1'b0};

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         raw_w[i] = req_tdata[i*N +: N];
         abs_w[i] = raw_w[i][N-1] ? (~raw_w[i] + N'(1)) : raw_w[i];
         // Only the most negative code gives a magnitude above full scale.
         mag_w[i] = abs_w[i][N-1] ? FS_LV : abs_w[i][LW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         qf_w[i]   = sat_ff[i] ? FS_LV : q_ff[i];
         cond_w[i] = neg_ff[i] ? (N'(0) - {1'b0, qf_w[i]}) : {1'b0, qf_w[i]};
      end
      defl_w[0] = (N+1)'(0) - {cond_w[1][N-1], cond_w[1]};
      defl_w[1] = {cond_w[1][N-1], cond_w[1]};
      defl_w[2] = (N+1)'(0) - {cond_w[0][N-1], cond_w[0]};
      defl_w[3] = {cond_w[0][N-1], cond_w[0]};
      for (int d = 0; d < 4; d++) begin
         latch_next[d] = latch_ff[d];
         pressed_w[d]  = 1'b0;
         released_w[d] = 1'b0;
         if (!latch_ff[d] && ($signed(defl_w[d]) >= $signed({2'b00, press_ff}))) begin
            latch_next[d] = 1'b1;
            pressed_w[d]  = 1'b1;
         end else if (latch_ff[d] && ($signed(defl_w[d]) < $signed({2'b00, rel_ff}))) begin
            latch_next[d] = 1'b0;
            released_w[d] = 1'b1;
         end
      end
   end

   always_comb begin
      logic [N+2:0] rt_rem4;
      logic [N+2:0] rt_trial;
      logic [2*N:0] dv_trial;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      latch_in     = latch_ff;
      rsp_valid_in = rsp_valid_ff;
      dz_in        = dz_ff;
      press_in     = press_ff;
      rel_in       = rel_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      s_in         = s_ff;
      root_rem_in  = root_rem_ff;
      root_in      = root_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      sat_in       = sat_ff;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      rt_rem4      = '0;
      rt_trial     = '0;
      dv_trial     = '0;
      req_tready   = (state_ff == ST_IDLE);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEADZONE: dz_in    = csr_wdata;
            CSR_PRESS:    press_in = csr_wdata;
            CSR_RELEASE:  rel_in   = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 2; i++) begin
                  mag_in[i] = mag_w[i];
                  neg_in[i] = raw_w[i][N-1];
               end
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            mul_a    = {1'b0, mag_ff[0]};
            mul_b    = {1'b0, mag_ff[0]};
            s_in     = prod;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            mul_a       = {1'b0, mag_ff[1]};
            mul_b       = {1'b0, mag_ff[1]};
            s_in        = s_ff + prod;
            root_rem_in = '0;
            root_in     = '0;
            cnt_in      = '0;
            state_in    = ST_ROOT;
         end
         ST_ROOT: begin
            // One root bit per cycle from the next two bits of the sum of squares.
            rt_rem4  = {root_rem_ff, s_ff[2*N-1 -: 2]};
            rt_trial = {1'b0, root_ff, 2'b01};
            if (rt_rem4 >= rt_trial) begin
               root_rem_in = rt_rem4[N:0] - rt_trial[N:0];
               root_in     = {root_ff[N-2:0], 1'b1};
            end else begin
               root_rem_in = rt_rem4[N:0];
               root_in     = {root_ff[N-2:0], 1'b0};
            end
            s_in   = {s_ff[2*N-3:0], 2'b00};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(N - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (root_ff > {1'b0, dz_eff}) begin
               diff_in  = root_ff - {1'b0, dz_eff};
               state_in = ST_MUL_X;
            end else begin
               for (int i = 0; i < 2; i++) begin
                  q_in[i]   = '0;
                  sat_in[i] = 1'b0;
               end
               state_in = ST_DONE;
            end
         end
         ST_MUL_X: begin
            mul_a     = {1'b0, mag_ff[0]};
            mul_b     = diff_ff;
            num_in[0] = (3*N)'(prod);
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            mul_a     = {1'b0, mag_ff[1]};
            mul_b     = diff_ff;
            num_in[1] = (3*N)'(prod);
            state_in  = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = {1'b0, FS_LV - dz_eff};
            mul_b    = root_ff;
            den_in   = prod;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // Twice the product times full scale: shift by N minus shift by one.
            for (int i = 0; i < 2; i++) begin
               num_in[i] = (num_ff[i] << N) - (num_ff[i] << 1);
            end
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            for (int i = 0; i < 2; i++) begin
               num_in[i] = num_ff[i] + (3*N)'(den_ff);
            end
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            // Any quotient bit at or above the sign position means saturation, so the
            // divider only has to produce the low LW bits.
            for (int i = 0; i < 2; i++) begin
               sat_in[i] = (num_ff[i][3*N-1 -: 2*N+1] >= dd);
               rem_in[i] = num_ff[i][N-1 +: 2*N];
               q_in[i]   = '0;
            end
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            for (int i = 0; i < 2; i++) begin
               dv_trial = {rem_ff[i], num_ff[i][N-2]};
               if (dv_trial >= dd) begin
                  rem_in[i] = dv_trial[2*N-1:0] - dd[2*N-1:0];
                  q_in[i]   = {q_ff[i][LW-2:0], 1'b1};
               end else begin
                  rem_in[i] = dv_trial[2*N-1:0];
                  q_in[i]   = {q_ff[i][LW-2:0], 1'b0};
               end
               num_in[i] = {num_ff[i][3*N-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(N - 2)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The result waits here only while the output register still holds one.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({released_w, pressed_w, latch_next,
                                      cond_w[1], cond_w[0]});
               latch_in     = latch_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dz_ff        <= LW'(DEADZONE_RESET);
         press_ff     <= LW'(PRESS_RESET);
         rel_ff       <= LW'(RELEASE_RESET);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
         dz_ff        <= dz_in;
         press_ff     <= press_in;
         rel_ff       <= rel_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      s_ff        <= s_in;
      root_rem_ff <= root_rem_in;
      root_ff     <= root_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/srdh_checker.sv]
`timescale 1ns / 1ps
`include "stick_radial_deadzone_hysteresis_defines.svh"

module srdh_checker #(
   parameter int SAMPLE_BITS = 16,
   parameter int RSP_W = 48
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int HELD_LSB = 2 * SAMPLE_BITS;
   localparam int PRESS_LSB = HELD_LSB + 4;
   localparam int REL_LSB = HELD_LSB + 8;
   localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   logic [SAMPLE_BITS-1:0] cond_x, cond_y;
   logic [3:0]             held, pressed, released;

   assign cond_x   = rsp_tdata[0 +: SAMPLE_BITS];
   assign cond_y   = rsp_tdata[SAMPLE_BITS +: SAMPLE_BITS];
   assign held     = rsp_tdata[HELD_LSB +: 4];
   assign pressed  = rsp_tdata[PRESS_LSB +: 4];
   assign released = rsp_tdata[REL_LSB +: 4];

   // A direction that set on this sample must now be held; one that cleared must not be.
   `SRDH_ASSERT_NOW(a_press_held, clock, reset, rsp_tvalid, (pressed & ~held) == 4'd0)
   `SRDH_ASSERT_NOW(a_release_clear, clock, reset, rsp_tvalid, (released & held) == 4'd0)
   // Saturation is symmetric, so the most negative code never appears.
   `SRDH_ASSERT_NOW(a_no_most_neg, clock, reset, rsp_tvalid, (cond_x != MOST_NEG) && (cond_y != MOST_NEG))
   `SRDH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind stick_radial_deadzone_hysteresis srdh_checker #(
   .SAMPLE_BITS(SAMPLE_BITS),
   .RSP_W(RSP_W)
) u_srdh_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
